// ----- hw/rtl/mpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and constants of the multi-probe pressure deform core
// Item structs, configuration register indexes, datapath step codes, the
// controller state type and the command/status bundles between the two.
// ----------------------------------------------------------------------------
package mpd_pkg;

	localparam int DEFAULT_MAX_PROBES = 16;

	// Q32.32 constants
	localparam logic [63:0] Q_ONE        = 64'h0000_0001_0000_0000;
	localparam logic [63:0] FATIGUE_RATE = 64'd4294967;           // 0.001
	localparam logic [62:0] STIFF_RESET  = 63'h0000_0001_0000_0000; // 1.0

	// configuration register indexes
	localparam logic [1:0] REG_STIFFNESS = 2'd0;
	localparam logic [1:0] REG_TIME_STEP = 2'd1;
	localparam logic [1:0] REG_ACTIVE    = 2'd2;

	// item operation codes
	localparam logic OPC_PROBE_WRITE = 1'b0;
	localparam logic OPC_VERTEX      = 1'b1;

	// probe word slots
	localparam logic [2:0] WORD_POS_X  = 3'd0;
	localparam logic [2:0] WORD_DIR_X  = 3'd3;
	localparam logic [2:0] WORD_FORCE  = 3'd6;
	localparam logic [2:0] WORD_RADIUS = 3'd7;

	typedef struct packed {
		logic               operation;
		logic [3:0]         probe_slot;
		logic [2:0]         probe_word;
		logic signed [63:0] probe_value;
		logic signed [63:0] pos_x;
		logic signed [63:0] pos_y;
		logic signed [63:0] pos_z;
		logic signed [63:0] vel_x;
		logic signed [63:0] vel_y;
		logic signed [63:0] vel_z;
		logic signed [63:0] fatigue_in;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] new_pos_x;
		logic signed [63:0] new_pos_y;
		logic signed [63:0] new_pos_z;
		logic signed [63:0] new_vel_x;
		logic signed [63:0] new_vel_y;
		logic signed [63:0] new_vel_z;
		logic signed [63:0] fatigue_out;
		logic               pressed;
	} out_item_t;

	// datapath steps, in issue order
	typedef enum logic [3:0] {
		OP_DX, OP_DY, OP_DZ, OP_R2, OP_SQRT, OP_W, OP_WW, OP_INT,
		OP_SHARE, OP_D0, OP_D1, OP_D2, OP_P0, OP_P1, OP_P2, OP_FAT
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_LOAD, S_LOAD_END, S_ISSUE, S_WAIT, S_CHECK, S_NEXT
	} state_t;

	typedef struct packed {
		op_t        op;
		logic       go;
		logic       rd_en;
		logic [2:0] rd_word;
		logic       next_probe;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic more;
		logic pressed;
		logic empty;
	} status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mpd_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_mul: Q32.32 multiplier
// Four 32x32 partial products, one per cycle, accumulated into a 128-bit
// unsigned product; a sign correction yields the signed product >> 32.
// ----------------------------------------------------------------------------
module mpd_mul import mpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      prod
);
	localparam logic [2:0] LAST = 3'd4;

	logic [63:0]  a_q, b_q, corr_q, pp_s1;
	logic [127:0] acc_q, pp_ext;
	logic [1:0]   idx_s1;
	logic [2:0]   cnt_q;
	logic         act_q, done_q;
	logic [31:0]  opa, opb;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin opa = a_q[31:0];  opb = b_q[31:0];  end
			2'd1: begin opa = a_q[31:0];  opb = b_q[63:32]; end
			2'd2: begin opa = a_q[63:32]; opb = b_q[31:0];  end
			default: begin opa = a_q[63:32]; opb = b_q[63:32]; end
		endcase
	end

	always_comb begin
		case (idx_s1)
			2'd0: pp_ext = {64'd0, pp_s1};
			2'd1, 2'd2: pp_ext = {32'd0, pp_s1, 32'd0};
			default: pp_ext = {pp_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			act_q  <= 1'b1;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= act_q && (cnt_q == LAST);
			if (act_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == LAST)
					act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q    <= a;
			b_q    <= b;
			corr_q <= (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
			acc_q  <= '0;
		end else if (act_q) begin
			if (cnt_q != LAST) begin
				pp_s1  <= 64'(opa) * 64'(opb);
				idx_s1 <= cnt_q[1:0];
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + pp_ext;
		end
	end

	assign done = done_q;
	assign prod = acc_q[95:32] - {corr_q[31:0], 32'd0};

endmodule
`default_nettype wire

// ----- hw/rtl/mpd_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_div: Q32.32 divider
// Restoring division of |a| << 32 by |b|, one quotient bit per cycle,
// truncated toward zero; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module mpd_div import mpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      quo
);
	localparam logic [6:0] LAST = 7'd95;

	logic [95:0] dvd_q;
	logic [63:0] rem_q, nb_q, q_q;
	logic        neg_q, zero_q;
	logic [6:0]  cnt_q;
	logic        act_q, done_q;
	logic [64:0] rem2, diff;
	logic        ge;
	logic [63:0] na, nb;

	assign na   = a[63] ? (64'd0 - a) : a;
	assign nb   = b[63] ? (64'd0 - b) : b;
	assign rem2 = {rem_q, dvd_q[95]};
	assign diff = rem2 - {1'b0, nb_q};
	assign ge   = (rem2 >= {1'b0, nb_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			act_q  <= 1'b1;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= act_q && (cnt_q == LAST);
			if (act_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == LAST)
					act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q  <= {na, 32'd0};
			nb_q   <= nb;
			rem_q  <= '0;
			q_q    <= '0;
			neg_q  <= a[63] ^ b[63];
			zero_q <= (nb == 64'd0);
		end else if (act_q) begin
			dvd_q <= {dvd_q[94:0], 1'b0};
			rem_q <= ge ? diff[63:0] : rem2[63:0];
			q_q   <= {q_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? 64'd0 : (neg_q ? (64'd0 - q_q) : q_q);

endmodule
`default_nettype wire

// ----- hw/rtl/mpd_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_sqrt: Q32.32 square root
// Digit recurrence on x << 32, one result bit per cycle, floored;
// a negative input gives zero.
// ----------------------------------------------------------------------------
module mpd_sqrt import mpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] x,
	output logic             done,
	output logic [63:0]      root
);
	localparam int         REM_W = 50;
	localparam logic [5:0] LAST  = 6'd47;

	logic [95:0]      n_q;
	logic [REM_W-1:0] rem_q;
	logic [47:0]      root_q;
	logic             neg_q;
	logic [5:0]       cnt_q;
	logic             act_q, done_q;
	logic [REM_W+1:0] rem2, trial, diff;
	logic             ge;

	assign rem2  = {rem_q, n_q[95:94]};
	assign trial = (REM_W+2)'({root_q, 2'b01});
	assign diff  = rem2 - trial;
	assign ge    = (rem2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			act_q  <= 1'b1;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= act_q && (cnt_q == LAST);
			if (act_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST)
					act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q    <= {x, 32'd0};
			rem_q  <= '0;
			root_q <= '0;
			neg_q  <= x[63];
		end else if (act_q) begin
			n_q    <= {n_q[93:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
			root_q <= {root_q[46:0], ge};
		end
	end

	assign done = done_q;
	assign root = neg_q ? 64'd0 : {16'd0, root_q};

endmodule
`default_nettype wire

// ----- hw/rtl/mpd_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_dp: datapath
// Probe store, configuration registers, vertex registers and the shared
// multiply, divide and square root units, stepped by the controller.
// ----------------------------------------------------------------------------
module mpd_dp import mpd_pkg::*; #(
	parameter int MAX_PROBES = DEFAULT_MAX_PROBES
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire in_item_t  item,
	input  wire logic      cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [62:0] cfg_data,
	input  wire cmd_t      cmd,
	output status_t        status,
	output logic           done,
	output out_item_t      result
);
	localparam int DEPTH = MAX_PROBES * 8;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_PROBES + 1);

	logic [63:0] mem [DEPTH];
	logic [63:0] rdata_q;
	logic [2:0]  rd_word_s1;
	logic        rd_vld_s1;
	logic [AW-1:0] waddr, raddr;
	logic        wr_en, vertex_go;

	logic [62:0] stiff_q, ts_q;
	logic [4:0]  active_q;
	logic [CW-1:0] count_q, pidx_q;

	logic [63:0] pr_q [8];
	logic [63:0] pos_q [3];
	logic [63:0] vel_q [3];
	logic [63:0] disp_q [3];
	logic [63:0] fat_q, total_q, divisor_q;
	logic [63:0] dsq_q, r2_q, dist_q, w_q, ww_q, inten_q, share_q;

	logic [63:0] mul_a, mul_b, div_a, div_b, mul_prod, div_quo, sqrt_root;
	logic        mul_go, div_go, sqrt_go, mul_done, div_done, sqrt_done, unit_done;
	logic        pressed, done_q;

	assign vertex_go = accept && (item.operation == OPC_VERTEX);
	assign wr_en = accept && (item.operation == OPC_PROBE_WRITE) &&
		(32'(item.probe_slot) < MAX_PROBES);
	assign waddr = AW'({item.probe_slot, item.probe_word});
	assign raddr = AW'({pidx_q, cmd.rd_word});

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= item.probe_value;
		if (cmd.rd_en)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld_s1 <= 1'b0;
		else
			rd_vld_s1 <= cmd.rd_en;
	end

	always_ff @(posedge clk) begin
		rd_word_s1 <= cmd.rd_word;
		if (rd_vld_s1)
			pr_q[rd_word_s1] <= rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q  <= STIFF_RESET;
			ts_q     <= '0;
			active_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STIFFNESS: stiff_q  <= cfg_data;
				REG_TIME_STEP: ts_q     <= cfg_data;
				REG_ACTIVE:    active_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// probe counter; saturate the active count at the store size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pidx_q  <= '0;
		end else if (vertex_go) begin
			count_q <= (32'(active_q) < MAX_PROBES) ? CW'(active_q) : CW'(MAX_PROBES);
			pidx_q  <= '0;
		end else if (cmd.next_probe) begin
			pidx_q <= pidx_q + CW'(1);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_DX: begin mul_a = pos_q[0] - pr_q[WORD_POS_X]; mul_b = mul_a; end
			OP_DY: begin mul_a = pos_q[1] - pr_q[1]; mul_b = mul_a; end
			OP_DZ: begin mul_a = pos_q[2] - pr_q[2]; mul_b = mul_a; end
			OP_R2: begin mul_a = pr_q[WORD_RADIUS]; mul_b = pr_q[WORD_RADIUS]; end
			OP_WW: begin mul_a = w_q; mul_b = w_q; end
			OP_INT: begin mul_a = pr_q[WORD_FORCE]; mul_b = ww_q; end
			OP_D0: begin mul_a = pr_q[WORD_DIR_X]; mul_b = share_q; end
			OP_D1: begin mul_a = pr_q[4]; mul_b = share_q; end
			OP_D2: begin mul_a = pr_q[5]; mul_b = share_q; end
			OP_P0: begin mul_a = disp_q[0]; mul_b = {1'b0, ts_q}; end
			OP_P1: begin mul_a = disp_q[1]; mul_b = {1'b0, ts_q}; end
			OP_P2: begin mul_a = disp_q[2]; mul_b = {1'b0, ts_q}; end
			OP_FAT: begin mul_a = total_q; mul_b = FATIGUE_RATE; end
			default: ;
		endcase
	end

	always_comb begin
		if (cmd.op == OP_W) begin
			div_a = pr_q[WORD_RADIUS] - dist_q;
			div_b = pr_q[WORD_RADIUS];
		end else begin
			div_a = inten_q;
			div_b = divisor_q;
		end
	end

	assign sqrt_go = cmd.go && (cmd.op == OP_SQRT);
	assign div_go  = cmd.go && ((cmd.op == OP_W) || (cmd.op == OP_SHARE));
	assign mul_go  = cmd.go && !sqrt_go && !div_go &&
		(cmd.op != OP_SQRT) && (cmd.op != OP_W) && (cmd.op != OP_SHARE);
	assign unit_done = mul_done || div_done || sqrt_done;

	mpd_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	mpd_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .a(div_a), .b(div_b),
		.done(div_done), .quo(div_quo)
	);

	mpd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(sqrt_go), .x(dsq_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	// latch the vertex, then write back each unit result by step
	always_ff @(posedge clk) begin
		if (vertex_go) begin
			pos_q[0]  <= item.pos_x;
			pos_q[1]  <= item.pos_y;
			pos_q[2]  <= item.pos_z;
			vel_q[0]  <= item.vel_x;
			vel_q[1]  <= item.vel_y;
			vel_q[2]  <= item.vel_z;
			fat_q     <= item.fatigue_in;
			disp_q[0] <= '0;
			disp_q[1] <= '0;
			disp_q[2] <= '0;
			total_q   <= '0;
			divisor_q <= {1'b0, stiff_q} + Q_ONE;
		end else if (unit_done) begin
			case (cmd.op)
				OP_DX:    dsq_q <= mul_prod;
				OP_DY, OP_DZ: dsq_q <= dsq_q + mul_prod;
				OP_R2:    r2_q <= mul_prod;
				OP_SQRT:  dist_q <= sqrt_root;
				OP_W:     w_q <= div_quo;
				OP_WW:    ww_q <= mul_prod;
				OP_INT:   inten_q <= mul_prod;
				OP_SHARE: share_q <= div_quo;
				OP_D0:    disp_q[0] <= disp_q[0] + mul_prod;
				OP_D1:    disp_q[1] <= disp_q[1] + mul_prod;
				OP_D2: begin
					disp_q[2] <= disp_q[2] + mul_prod;
					total_q   <= total_q + inten_q;
				end
				OP_P0:    pos_q[0] <= pos_q[0] + mul_prod;
				OP_P1:    pos_q[1] <= pos_q[1] + mul_prod;
				OP_P2:    pos_q[2] <= pos_q[2] + mul_prod;
				OP_FAT:   fat_q <= fat_q + mul_prod;
				default: ;
			endcase
		end
	end

	assign pressed = (total_q != 64'd0) && !total_q[63];

	always_comb begin
		status.done    = unit_done;
		status.hit     = $signed(dsq_q) < $signed(r2_q);
		status.more    = (32'(pidx_q) + 32'd1) < 32'(count_q);
		status.pressed = pressed;
		status.empty   = (count_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.finish;
	end

	// halving the velocity is the Q32.32 product by 0.5, an arithmetic shift;
	// the fatigue step ends in the finishing cycle, so take its sum directly
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.new_pos_x   <= pos_q[0];
			result.new_pos_y   <= pos_q[1];
			result.new_pos_z   <= pos_q[2];
			result.new_vel_x   <= pressed ? {vel_q[0][63], vel_q[0][63:1]} : vel_q[0];
			result.new_vel_y   <= pressed ? {vel_q[1][63], vel_q[1][63:1]} : vel_q[1];
			result.new_vel_z   <= pressed ? {vel_q[2][63], vel_q[2][63:1]} : vel_q[2];
			result.fatigue_out <= (unit_done && (cmd.op == OP_FAT)) ?
				(fat_q + mul_prod) : fat_q;
			result.pressed     <= pressed;
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

// ----- hw/rtl/mpd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_ctrl: controller
// Sequences probe loads and datapath steps for one vertex at a time.
// ----------------------------------------------------------------------------
module mpd_ctrl import mpd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    vertex_go,
	input  wire status_t status,
	output logic         busy,
	output cmd_t         cmd
);
	state_t     state_q, state_n;
	op_t        op_q, op_n;
	logic [2:0] wcnt_q, wcnt_n;

	function automatic op_t succ(input op_t op);
		case (op)
			OP_DX:    succ = OP_DY;
			OP_DY:    succ = OP_DZ;
			OP_DZ:    succ = OP_R2;
			OP_SQRT:  succ = OP_W;
			OP_W:     succ = OP_WW;
			OP_WW:    succ = OP_INT;
			OP_INT:   succ = OP_SHARE;
			OP_SHARE: succ = OP_D0;
			OP_D0:    succ = OP_D1;
			OP_D1:    succ = OP_D2;
			OP_P0:    succ = OP_P1;
			OP_P1:    succ = OP_P2;
			OP_P2:    succ = OP_FAT;
			default:  succ = OP_DX;
		endcase
	endfunction

	always_comb begin
		state_n = state_q;
		op_n    = op_q;
		wcnt_n  = wcnt_q;
		case (state_q)
			S_IDLE: begin
				if (vertex_go)
					state_n = S_INIT;
			end
			S_INIT: begin
				wcnt_n = '0;
				if (status.empty)
					state_n = S_IDLE;
				else
					state_n = S_LOAD;
			end
			S_LOAD: begin
				wcnt_n = wcnt_q + 3'd1;
				if (wcnt_q == 3'd7)
					state_n = S_LOAD_END;
			end
			S_LOAD_END: begin
				op_n    = OP_DX;
				state_n = S_ISSUE;
			end
			S_ISSUE: state_n = S_WAIT;
			S_WAIT: begin
				if (status.done) begin
					case (op_q)
						OP_R2: begin
							op_n    = OP_SQRT;
							state_n = S_CHECK;
						end
						OP_D2:  state_n = S_NEXT;
						OP_FAT: state_n = S_IDLE;
						default: begin
							op_n    = succ(op_q);
							state_n = S_ISSUE;
						end
					endcase
				end
			end
			S_CHECK: state_n = status.hit ? S_ISSUE : S_NEXT;
			S_NEXT: begin
				wcnt_n = '0;
				if (status.more) begin
					state_n = S_LOAD;
				end else if (status.pressed) begin
					op_n    = OP_P0;
					state_n = S_ISSUE;
				end else begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_DX;
			wcnt_q  <= '0;
		end else begin
			state_q <= state_n;
			op_q    <= op_n;
			wcnt_q  <= wcnt_n;
		end
	end

	// finish on every path that returns to idle from a busy state
	always_comb begin
		busy           = (state_q != S_IDLE);
		cmd.op         = op_q;
		cmd.go         = (state_q == S_ISSUE);
		cmd.rd_en      = (state_q == S_LOAD);
		cmd.rd_word    = wcnt_q;
		cmd.next_probe = (state_q == S_NEXT);
		cmd.finish     = (state_q != S_IDLE) && (state_n == S_IDLE);
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> (state_q == S_WAIT))
		else $error("unit finished outside wait");
	a_issue_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |=> (state_q == S_WAIT))
		else $error("issue not followed by wait");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == S_IDLE))
		else $error("finish without return to idle");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.go, cmd.rd_en, cmd.next_probe}))
		else $error("overlapping commands");

endmodule
`default_nettype wire

// ----- hw/rtl/multi_probe_pressure_deform_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_probe_pressure_deform_core: multi-probe pressure deformation
// Probe store plus a per-vertex pressure test against each active probe.
// ----------------------------------------------------------------------------
// Work: a probe write gives no result. A vertex loads and tests each active probe
//   (three distance multiplies and a radius multiply); a probe inside its radius
//   adds two divides, a square root and five further multiplies in the shared
//   iterative units, and a pressed vertex adds the position and fatigue steps.
// Throughput: one vertex at a time; the next item is taken the cycle done pulses.
// Reset: arst_n resets control and configuration (stiffness to 1.0, the rest to zero); the probe store is not cleared.
// The receiver cannot stall: result is valid only in the cycle done is high.
module multi_probe_pressure_deform_core import mpd_pkg::*; #(
	parameter int MAX_PROBES = DEFAULT_MAX_PROBES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_item_t    item,
	output logic             done,
	output out_item_t        result,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [62:0] cfg_data
);
	cmd_t    cmd;
	status_t status;
	logic    accept, vertex_go;

	// take an item whenever the controller is idle
	assign accept    = start && !busy;
	assign vertex_go = accept && (item.operation == OPC_VERTEX);

	mpd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.vertex_go(vertex_go),
		.status(status),
		.busy(busy),
		.cmd(cmd)
	);

	// probe writes go straight into the store at accept
	mpd_dp #(.MAX_PROBES(MAX_PROBES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status),
		.done(done),
		.result(result)
	);

endmodule
`default_nettype wire
